### src/adsr_eg_pkg.sv
// Package for the ADSR envelope generator: state type, phase and register
// codes, rate tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package adsr_eg_pkg;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned RATE_W  = 17;
   localparam int unsigned REG_W   = 8;
   localparam int unsigned INDEX_W = 1;
   localparam int unsigned STEPS_PER_TICK_DEF = 2;

   localparam logic [PHASE_W-1:0] PHASE_ATTACK  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_DECAY   = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_SUSTAIN = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_RELEASE = 2'd3;

   localparam logic [INDEX_W-1:0] REG_ATTACK_DECAY    = 1'b0;
   localparam logic [INDEX_W-1:0] REG_SUSTAIN_RELEASE = 1'b1;

   localparam logic MODE_TICK = 1'b0;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [PHASE_W-1:0] phase;
      logic [RATE_W-1:0]  count;
      logic [RATE_W-1:0]  limit;
      logic               last_gate;
   } env_state_type;

   function automatic logic [RATE_W-1:0] attack_rate(input logic [3:0] sel);
      logic [RATE_W-1:0] r;
      unique case (sel)
         4'd0:  r = 17'd9;
         4'd1:  r = 17'd32;
         4'd2:  r = 17'd63;
         4'd3:  r = 17'd95;
         4'd4:  r = 17'd149;
         4'd5:  r = 17'd220;
         4'd6:  r = 17'd267;
         4'd7:  r = 17'd313;
         4'd8:  r = 17'd392;
         4'd9:  r = 17'd977;
         4'd10: r = 17'd1954;
         4'd11: r = 17'd3126;
         4'd12: r = 17'd3906;
         4'd13: r = 17'd11720;
         4'd14: r = 17'd19531;
         default: r = 17'd31251;
      endcase
      return r;
   endfunction

   function automatic logic [RATE_W-1:0] fall_rate(input logic [3:0] sel);
      logic [RATE_W-1:0] r;
      unique case (sel)
         4'd0:  r = 17'd28;
         4'd1:  r = 17'd87;
         4'd2:  r = 17'd173;
         4'd3:  r = 17'd262;
         4'd4:  r = 17'd410;
         4'd5:  r = 17'd606;
         4'd6:  r = 17'd731;
         4'd7:  r = 17'd859;
         4'd8:  r = 17'd1077;
         4'd9:  r = 17'd2732;
         4'd10: r = 17'd5464;
         4'd11: r = 17'd8741;
         4'd12: r = 17'd10928;
         4'd13: r = 17'd32782;
         4'd14: r = 17'd54657;
         default: r = 17'd87419;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### src/adsr_envelope_generator.sv
// ADSR envelope generator for one voice, top level.
// Depends on adsr_eg_pkg, adsr_eg_step, adsr_eg_regs.
//
// Usage:
//   req_ stream: one item per transfer, either a sample tick (tuser 0) or a
//     gate control write (tuser 1, gate in tdata[0]).
//   rsp_ stream: one result per item, the envelope level and phase after it.
//   csr_ port: write attack_decay (index 0) or sustain_release (index 1);
//     write only while no item is in flight.
// Timing:
//   An accepted item is loaded into the input register; when it advances,
//   its result is loaded into the result register that drives rsp_tvalid.
//   One item per cycle sustained while rsp_tready is high; the combinational
//   path is the rate counter subtract/compare plus the level update.
// Reset:
//   Synchronous. Level 0, attack phase, rate limit 0 (frozen), both
//   configuration registers 0, both stages empty.
// Stall:
//   While rsp_tready is low with a result held, the input register keeps its
//   item and req_tready drops once it is full; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module adsr_envelope_generator #(
   parameter int unsigned STEPS_PER_TICK = adsr_eg_pkg::STEPS_PER_TICK_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [0] gate_level
   input  logic                            req_tuser,   // [0] mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [7:0] level, [9:8] phase
   input  logic                            csr_we,
   input  logic [adsr_eg_pkg::INDEX_W-1:0] csr_index,
   input  logic [adsr_eg_pkg::REG_W-1:0]   csr_wdata
);
   import adsr_eg_pkg::*;

   logic               in_vld_ff, in_vld_in;
   logic               in_mode_ff;
   logic               in_gate_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;
   logic               advance;
   logic               take;
   env_state_type      cur, nxt;
   logic [REG_W-1:0]   attack_decay, sustain_release;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign in_vld_in  = take || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_tready);

   adsr_eg_step #(
      .STEPS_PER_TICK(STEPS_PER_TICK)
   ) u_step (
      .cur            (cur),
      .mode           (in_mode_ff),
      .gate_level     (in_gate_ff),
      .attack_decay   (attack_decay),
      .sustain_release(sustain_release),
      .nxt            (nxt)
   );

   adsr_eg_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .advance        (advance),
      .nxt            (nxt),
      .cur            (cur),
      .attack_decay   (attack_decay),
      .sustain_release(sustain_release)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req_tuser;
         in_gate_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_level_ff <= nxt.level;
         rsp_phase_ff <= nxt.phase;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_phase_ff, rsp_level_ff};

   // a transfer into the core always produces a result
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("result not presented after core transfer");

   // frozen envelope: ticks leave the level alone
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_mode_ff == MODE_TICK && cur.limit == '0) |=> $stable(cur.level))
      else $error("level moved while frozen");

   // release never raises the level
   assert property (@(posedge clock) disable iff (reset)
      (advance && cur.phase == PHASE_RELEASE) |=> (cur.level <= $past(cur.level)))
      else $error("level rose during release");

   // a held input item stays put while the result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready) |=> (in_vld_ff || !$past(in_vld_ff)))
      else $error("input item lost under stall");

endmodule
`default_nettype wire

### src/adsr_eg_step.sv
// Next-state logic for one item: gate write (restart on a change) or one tick of rate steps.
// Depends on adsr_eg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module adsr_eg_step #(
   parameter int unsigned STEPS_PER_TICK = adsr_eg_pkg::STEPS_PER_TICK_DEF
) (
   input  adsr_eg_pkg::env_state_type cur,
   input  logic                       mode,
   input  logic                       gate_level,
   input  logic [adsr_eg_pkg::REG_W-1:0] attack_decay,
   input  logic [adsr_eg_pkg::REG_W-1:0] sustain_release,
   output adsr_eg_pkg::env_state_type nxt
);
   import adsr_eg_pkg::*;

   localparam logic [RATE_W-1:0] STEPS   = RATE_W'(STEPS_PER_TICK);
   localparam logic [RATE_W-1:0] STEPS_1 = RATE_W'(STEPS_PER_TICK - 1);

   logic [LEVEL_W-1:0] sus;
   logic               frozen;
   logic               ahead;
   logic [RATE_W-1:0]  gap;
   logic               fire;

   assign sus    = {sustain_release[7:4], sustain_release[7:4]};
   assign frozen = (cur.limit == '0);
   assign ahead  = (cur.count >= cur.limit);
   assign gap    = cur.limit - cur.count;
   // limits are at least 9, so one tick fires at most once
   assign fire   = !frozen && (ahead || (gap <= STEPS));

   always_comb begin
      nxt = cur;
      if (mode != MODE_TICK) begin
         nxt.last_gate = gate_level;
         if (gate_level != cur.last_gate) begin
            nxt.count = '0;
            if (gate_level) begin
               nxt.phase = PHASE_ATTACK;
               nxt.limit = attack_rate(attack_decay[7:4]);
            end else begin
               nxt.phase = PHASE_RELEASE;
               nxt.limit = fall_rate(sustain_release[3:0]);
            end
         end
      end else if (!frozen) begin
         if (!fire) begin
            nxt.count = cur.count + STEPS;
         end else begin
            nxt.count = ahead ? STEPS_1 : (STEPS - gap);
            unique case (cur.phase)
               PHASE_ATTACK: begin
                  if (cur.level >= (LEVEL_FULL - 8'd1)) begin
                     nxt.level = LEVEL_FULL;
                     nxt.phase = PHASE_DECAY;
                     nxt.limit = fall_rate(attack_decay[3:0]);
                  end else begin
                     nxt.level = cur.level + 8'd1;
                  end
               end
               PHASE_DECAY: begin
                  if ({1'b0, cur.level} > ({1'b0, sus} + 9'd1)) begin
                     nxt.level = cur.level - 8'd1;
                  end else begin
                     nxt.level = sus;
                     nxt.phase = PHASE_SUSTAIN;
                  end
               end
               PHASE_SUSTAIN: nxt.level = sus;
               default: begin
                  if (cur.level != '0) begin
                     nxt.level = cur.level - 8'd1;
                  end
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

### src/adsr_eg_regs.sv
// Envelope state and configuration registers, with rate reload on writes.
// Depends on adsr_eg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module adsr_eg_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [adsr_eg_pkg::INDEX_W-1:0] csr_index,
   input  logic [adsr_eg_pkg::REG_W-1:0] csr_wdata,
   input  logic                          advance,
   input  adsr_eg_pkg::env_state_type    nxt,
   output adsr_eg_pkg::env_state_type    cur,
   output logic [adsr_eg_pkg::REG_W-1:0] attack_decay,
   output logic [adsr_eg_pkg::REG_W-1:0] sustain_release
);
   import adsr_eg_pkg::*;

   env_state_type     state_ff, state_in;
   logic [REG_W-1:0]  ad_ff, ad_in;
   logic [REG_W-1:0]  sr_ff, sr_in;

   always_comb begin
      state_in = state_ff;
      ad_in    = ad_ff;
      sr_in    = sr_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ATTACK_DECAY: begin
               ad_in = csr_wdata;
               if (state_ff.phase == PHASE_ATTACK) begin
                  state_in.limit = attack_rate(csr_wdata[7:4]);
               end else if (state_ff.phase == PHASE_DECAY) begin
                  state_in.limit = fall_rate(csr_wdata[3:0]);
               end
            end
            default: begin
               sr_in = csr_wdata;
               if (state_ff.phase == PHASE_RELEASE) begin
                  state_in.limit = fall_rate(csr_wdata[3:0]);
               end
            end
         endcase
      end
      if (advance) begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         ad_ff    <= '0;
         sr_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ad_ff    <= ad_in;
         sr_ff    <= sr_in;
      end
   end

   assign cur             = state_ff;
   assign attack_decay    = ad_ff;
   assign sustain_release = sr_ff;

endmodule
`default_nettype wire
